/* rtl/slri_pkg.sv */
// Shared types and status codes for the sorted list insert/remove core.
package slri_pkg;

  localparam int unsigned StatusBits    = 2;
  localparam int unsigned OccupancyBits = 5;
  localparam int unsigned PortValueBits = 32;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } req_type_e;

  typedef enum logic [StatusBits-1:0] {
    ST_INSERTED  = 2'd0,
    ST_REMOVED   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // Per-transaction command broadcast to every cell
  typedef struct packed {
    logic ins_en;
    logic rem_en;
  } cell_cmd_t;

  // Compare flags a cell hands to its right-hand neighbor
  typedef struct packed {
    logic gt;
    logic eq;
  } cell_flags_t;

endpackage

/* rtl/slri_cell.sv */
// One storage cell of the sorted chain: compare against the key, then shift or load.
module slri_cell import slri_pkg::*; #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                         clk_i,
  input  logic signed [VALUE_BITS-1:0] key_i,
  input  cell_cmd_t                    cmd_i,
  input  logic                         valid_i,
  input  logic signed [VALUE_BITS-1:0] left_val_i,
  input  cell_flags_t                  left_flags_i,
  input  logic signed [VALUE_BITS-1:0] right_val_i,
  input  logic                         right_exists_i,
  output logic signed [VALUE_BITS-1:0] val_o,
  output cell_flags_t                  flags_o
);

  logic signed [VALUE_BITS-1:0] val_q;
  logic signed [VALUE_BITS-1:0] val_d;
  logic                         gt;
  logic                         eq;

  assign gt = valid_i && (val_q > key_i);
  assign eq = valid_i && (val_q == key_i);

  always_comb begin
    val_d = val_q;
    if (cmd_i.ins_en) begin
      // take the left entry when it moves right; otherwise load the key at the gap
      if (left_flags_i.gt) begin
        val_d = left_val_i;
      end else if (!valid_i || gt) begin
        val_d = key_i;
      end
    end else if (cmd_i.rem_en) begin
      // every entry at or above the key advances one place toward the head
      if ((gt || eq) && right_exists_i) begin
        val_d = right_val_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o      = val_q;
  assign flags_o.gt = gt;
  assign flags_o.eq = eq;

endmodule

/* rtl/sorted_list_insert_remove_core.sv */
// Result: done_o strobes in the cycle after an accepted start, carrying the result.
// Throughput: one transaction per cycle; busy stays low, and all cells update together at the clock edge.
// Every cell compares the broadcast key in parallel and shifts toward its neighbor.
// Reset clears the entry count and the result strobe; cell contents stay undefined
// until written and are never shown past the count.
// The result is valid on done_o for exactly one cycle; the receiver cannot stall.
module sorted_list_insert_remove_core import slri_pkg::*; #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     req_type_i,
  input  logic [PortValueBits-1:0] value_i,
  output logic                     done_o,
  output logic [StatusBits-1:0]    status_o,
  output logic [OccupancyBits-1:0] occupancy_o,
  output logic [PortValueBits-1:0] smallest_value_o
);

  localparam int unsigned CountBits = $clog2(CAPACITY + 1);

  logic signed [VALUE_BITS-1:0] key;
  logic signed [VALUE_BITS-1:0] cell_val [CAPACITY];
  cell_flags_t                  cell_flags [CAPACITY];
  logic [CAPACITY-1:0]          cell_valid;
  logic [CAPACITY-1:0]          cell_eq;
  cell_cmd_t                    cmd;

  logic [CountBits-1:0] count_q, count_d;
  logic                 done_q;
  status_e              status_q, status_d;

  logic accept;
  logic full;
  logic found;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign key    = VALUE_BITS'(signed'(value_i));
  assign full   = (count_q >= CountBits'(CAPACITY));
  assign found  = |cell_eq;

  assign cmd.ins_en = accept && (req_type_i == REQ_INSERT) && !full;
  assign cmd.rem_en = accept && (req_type_i == REQ_REMOVE) && found;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_BITS-1:0] left_val;
    cell_flags_t                  left_flags;
    logic signed [VALUE_BITS-1:0] right_val;
    logic                         right_exists;

    assign cell_valid[i] = (CountBits'(i) < count_q);
    assign cell_eq[i]    = cell_flags[i].eq;

    if (i == 0) begin : g_head
      assign left_val   = '0;
      assign left_flags = '0;
    end else begin : g_body
      assign left_val   = cell_val[i-1];
      assign left_flags = cell_flags[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_val    = cell_val[i];
      assign right_exists = 1'b0;
    end else begin : g_inner
      assign right_val    = cell_val[i+1];
      assign right_exists = 1'b1;
    end

    slri_cell #(
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .key_i         (key),
      .cmd_i         (cmd),
      .valid_i       (cell_valid[i]),
      .left_val_i    (left_val),
      .left_flags_i  (left_flags),
      .right_val_i   (right_val),
      .right_exists_i(right_exists),
      .val_o         (cell_val[i]),
      .flags_o       (cell_flags[i])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = status_q;
    if (accept) begin
      unique case (req_type_i)
        REQ_INSERT: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            status_d = ST_INSERTED;
            count_d  = count_q + CountBits'(1);
          end
        end
        REQ_REMOVE: begin
          if (found) begin
            status_d = ST_REMOVED;
            count_d  = count_q - CountBits'(1);
          end else begin
            status_d = ST_NOT_FOUND;
          end
        end
        default: status_d = status_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      done_q   <= 1'b0;
      status_q <= ST_INSERTED;
    end else begin
      count_q  <= count_d;
      done_q   <= accept;
      status_q <= status_d;
    end
  end

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign occupancy_o      = OccupancyBits'(count_q);
  assign smallest_value_o = (count_q != '0) ? PortValueBits'(signed'(cell_val[0])) : '0;

endmodule

/* rtl/slri_checker.sv */
// Port-level checks for the sorted list core, attached by bind.
module slri_checker import slri_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     start,
  input logic                     busy,
  input logic                     done_o,
  input logic [StatusBits-1:0]    status_o,
  input logic [OccupancyBits-1:0] occupancy_o,
  input logic [PortValueBits-1:0] smallest_value_o
);

  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> done_o)
    else $error("accepted transaction produced no result strobe");

  a_no_spurious_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> !done_o)
    else $error("result strobe without an accepted transaction");

  a_full_at_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_FULL) |-> (occupancy_o == OccupancyBits'(CAPACITY)))
    else $error("full reported below capacity");

  a_empty_head_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && occupancy_o == '0 && CAPACITY < 32) |-> (smallest_value_o == '0))
    else $error("empty list reports a nonzero head");

  a_inserted_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_INSERTED && CAPACITY < 32) |-> (occupancy_o != '0))
    else $error("insert reported with an empty list");

endmodule

bind sorted_list_insert_remove_core slri_checker #(
  .CAPACITY(CAPACITY)
) u_slri_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .done_o          (done_o),
  .status_o        (status_o),
  .occupancy_o     (occupancy_o),
  .smallest_value_o(smallest_value_o)
);

/* test/sorted_list_insert_remove_core_tb.sv */
// Self-checking testbench for the sorted list insert/remove core with a scoreboard class.
module sorted_list_insert_remove_core_tb;
  import slri_pkg::*;

  localparam int unsigned ListDepth = 16;

  typedef struct {
    status_e                  status;
    logic [OccupancyBits-1:0] occupancy;
    logic [PortValueBits-1:0] smallest;
  } list_result_t;

  // Tracks the list contents and the results still owed by the core
  class sorted_list_tracker;
    logic signed [PortValueBits-1:0] entries[$];
    list_result_t                    owed_results[$];
    int unsigned                     fault_count = 0;

    function void report_fault(string what);
      if (fault_count < 10) $display("MISMATCH at %0t: %s", $time, what);
      fault_count++;
    endfunction

    function void note_request(req_type_e req, logic [PortValueBits-1:0] val);
      list_result_t res;
      int unsigned  pos;
      pos = 0;
      if (req == REQ_INSERT) begin
        if (entries.size() >= ListDepth) begin
          res.status = ST_FULL;
        end else begin
          // place after every equal entry
          while (pos < entries.size() && entries[pos] <= $signed(val)) pos++;
          entries.insert(pos, $signed(val));
          res.status = ST_INSERTED;
        end
      end else begin
        while (pos < entries.size() && entries[pos] != $signed(val)) pos++;
        if (pos >= entries.size()) begin
          res.status = ST_NOT_FOUND;
        end else begin
          entries.delete(pos);
          res.status = ST_REMOVED;
        end
      end
      res.occupancy = OccupancyBits'(entries.size());
      res.smallest  = (entries.size() != 0) ? entries[0] : '0;
      owed_results.push_back(res);
    endfunction

    function void check_result(logic [StatusBits-1:0] status, logic [OccupancyBits-1:0] occ,
                               logic [PortValueBits-1:0] smallest);
      list_result_t exp_res;
      if (owed_results.size() == 0) begin
        report_fault($sformatf("result with none owed: status %0d occ %0d smallest %h",
                               status, occ, smallest));
        return;
      end
      exp_res = owed_results.pop_front();
      if (status !== exp_res.status)
        report_fault($sformatf("status expected %0d got %0d", exp_res.status, status));
      if (occ !== exp_res.occupancy)
        report_fault($sformatf("occupancy expected %0d got %0d", exp_res.occupancy, occ));
      if (smallest !== exp_res.smallest)
        report_fault($sformatf("smallest expected %h got %h", exp_res.smallest, smallest));
    endfunction

    function int unsigned owed_count();
      return owed_results.size();
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     req_type_i = 1'b0;
  logic [PortValueBits-1:0] value_i = '0;
  logic                     done_o;
  logic [StatusBits-1:0]    status_o;
  logic [OccupancyBits-1:0] occupancy_o;
  logic [PortValueBits-1:0] smallest_value_o;

  sorted_list_tracker tracker = new();
  int unsigned        idle_pct = 0;
  logic [PortValueBits-1:0] value_pool[6];

  sorted_list_insert_remove_core #(
    .CAPACITY  (ListDepth),
    .VALUE_BITS(PortValueBits)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .req_type_i      (req_type_i),
    .value_i         (value_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .occupancy_o     (occupancy_o),
    .smallest_value_o(smallest_value_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) tracker.check_result(status_o, occupancy_o, smallest_value_o);
  end

  task automatic send_item(input req_type_e req, input logic [PortValueBits-1:0] val);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start      <= 1'b1;
    req_type_i <= req;
    value_i    <= val;
    do @(posedge clk_i); while (!(start && !busy));
    tracker.note_request(req, val);
  endtask

  // Hold off until every owed result has come back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (tracker.owed_count() != 0);
  endtask

  task automatic fill_pool();
    for (int k = 0; k < 6; k++) begin
      case ($urandom_range(3))
        0:       value_pool[k] = $urandom_range(15);
        1:       value_pool[k] = -$urandom_range(15);
        2:       value_pool[k] = $urandom;
        default: value_pool[k] = $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      endcase
    end
  endtask

  task automatic random_chunk(input int unsigned count, input int unsigned ins_pct);
    req_type_e                req;
    logic [PortValueBits-1:0] val;
    int unsigned              pick;
    fill_pool();
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < ins_pct) begin
        req = REQ_INSERT;
      end else begin
        req = REQ_REMOVE;
      end
      pick = $urandom_range(99);
      if (pick < 50 || (pick < 80 && tracker.entries.size() == 0))
        val = value_pool[$urandom_range(5)];
      else if (pick < 80)
        val = tracker.entries[$urandom_range(tracker.entries.size() - 1)];
      else
        val = $urandom;
      send_item(req, val);
    end
  endtask

  initial begin
    int unsigned phase_idle[3];
    int unsigned bias[4];
    phase_idle[0] = 0;
    phase_idle[1] = 47;
    phase_idle[2] = 26;
    bias[0] = 70;
    bias[1] = 50;
    bias[2] = 30;
    bias[3] = 55;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty remove, extremes, duplicates, full list, absent value
    send_item(REQ_REMOVE, 32'd0);
    send_item(REQ_INSERT, 32'h8000_0000);
    send_item(REQ_INSERT, 32'h7fff_ffff);
    send_item(REQ_INSERT, 32'd0);
    send_item(REQ_INSERT, 32'hffff_ffff);
    send_item(REQ_INSERT, 32'd5);
    send_item(REQ_INSERT, 32'd5);
    send_item(REQ_INSERT, 32'd5);
    send_item(REQ_INSERT, -32'd7);
    send_item(REQ_INSERT, 32'd3);
    send_item(REQ_INSERT, 32'd3);
    send_item(REQ_INSERT, 32'd42);
    send_item(REQ_INSERT, -32'd100000);
    send_item(REQ_INSERT, 32'd1);
    send_item(REQ_INSERT, 32'd2);
    send_item(REQ_INSERT, 32'd99);
    send_item(REQ_INSERT, 32'd8);
    send_item(REQ_INSERT, 32'd77);
    send_item(REQ_REMOVE, 32'd12345);
    send_item(REQ_REMOVE, 32'd5);
    send_item(REQ_REMOVE, 32'h8000_0000);
    send_item(REQ_REMOVE, 32'h7fff_ffff);
    drain();

    for (int c = 0; c < 12; c++) begin
      idle_pct = phase_idle[c % 3];
      random_chunk(170, bias[c % 4]);
      if (c % 3 == 1) drain();
    end
    idle_pct = 0;

    drain();
    repeat (4) @(posedge clk_i);
    if (tracker.fault_count == 0 && tracker.owed_count() == 0) begin
      $display("sorted_list_insert_remove_core verification clean");
    end else begin
      $display("sorted_list_insert_remove_core verification failed");
    end
    $finish;
  end

  initial begin
    #(400_000 * 4);
    $display("sorted_list_insert_remove_core verification failed");
    $finish;
  end

endmodule
